// ===== design/hcx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hcx_pkg;

  localparam int unsigned BlockBits = 256;

  localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] REG_INIT_VECTOR = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sha_h0(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] r;
    unique case (idx)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/hcx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcx_front import hcx_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output head_t           head_o,
  input  wire logic       pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign head_o     = '{valid: (cnt_q != 2'd0), item: mem_q[rd_ptr_q]};

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{data: data_byte_i, last: last_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

// ===== design/hcx_sha.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcx_sha import hcx_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [BlockBits-1:0] blk_i,
  input  wire logic [63:0]          iv_i,
  output logic                      done_o,
  output logic [BlockBits-1:0]      digest_o
);

  logic [31:0] st_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic        busy_q, done_q;
  logic [31:0] t1, t2, s0, s1, w_new;

  always_comb begin
    t1 = st_q[7] + (rotr(st_q[4], 6) ^ rotr(st_q[4], 11) ^ rotr(st_q[4], 25))
       + ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6])) + sha_k(rnd_q) + w_q[0];
    t2 = (rotr(st_q[0], 2) ^ rotr(st_q[0], 13) ^ rotr(st_q[0], 22))
       + ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]));
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      digest_o[32*k +: 32] = bswap32(sha_h0(3'(k)) + st_q[k]);
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int k = 0; k < 8; k++) begin
        st_q[k] <= sha_h0(3'(k));
        w_q[k]  <= bswap32(blk_i[32*k +: 32]);
      end
      w_q[8]  <= bswap32(iv_i[31:0]);
      w_q[9]  <= bswap32(iv_i[63:32]);
      w_q[10] <= 32'h80000000;
      for (int k = 11; k < 15; k++) w_q[k] <= 32'h0;
      w_q[15] <= 32'h00000140;   // 320-bit message length
    end else if (busy_q) begin
      st_q[0] <= t1 + t2;
      st_q[1] <= st_q[0];
      st_q[2] <= st_q[1];
      st_q[3] <= st_q[2];
      st_q[4] <= st_q[3] + t1;
      st_q[5] <= st_q[4];
      st_q[6] <= st_q[5];
      st_q[7] <= st_q[6];
      for (int k = 0; k < 15; k++) w_q[k] <= w_q[k+1];
      w_q[15] <= w_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rnd_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (rnd_q == 6'd63);
      if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/hcx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcx_back import hcx_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire head_t                head_i,
  output logic                      pop_o,
  input  wire logic [BlockBits-1:0] key_i,
  input  wire logic [63:0]          iv_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      out_last_o
);

  logic [BlockBits-1:0] blk_q, nxt_q, src, digest;
  logic                 nxt_vld_q, in_msg_q, out_vld_q;
  logic [4:0]           pos_q, pos_eff;
  logic [7:0]           out_byte_q;
  logic                 out_last_q;
  logic                 ks_ok, fire, start, done;

  assign ks_ok = !(in_msg_q && (pos_q == 5'd0) && !nxt_vld_q);
  assign fire  = head_i.valid && ks_ok && (!out_vld_q || out_ready_i);
  assign start = fire && (!in_msg_q || (pos_q == 5'd0));
  assign pop_o = fire;

  always_comb begin
    priority if (!in_msg_q) src = key_i;
    else if (pos_q == 5'd0) src = nxt_q;
    else                    src = blk_q;
  end
  assign pos_eff = in_msg_q ? pos_q : 5'd0;

  hcx_sha u_sha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .blk_i    (src),
    .iv_i     (iv_i),
    .done_o   (done),
    .digest_o (digest)
  );

  always_ff @(posedge clk_i) begin
    if (start) blk_q <= src;
    if (done && !start) nxt_q <= digest;
    if (fire) begin
      out_byte_q <= head_i.item.data ^ src[{pos_eff, 3'b000} +: 8];
      out_last_q <= head_i.item.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_vld_q <= 1'b0;
      in_msg_q  <= 1'b0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // restart of the hash engine drops any block in flight
      if (start) nxt_vld_q <= 1'b0;
      else if (done) nxt_vld_q <= 1'b1;
      if (fire) begin
        in_msg_q <= !head_i.item.last;
        pos_q    <= pos_eff + 5'd1;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ===== design/hash_chain_keystream_xor_cipher.sv =====
// Channel  | Handshake             | Payload
// in       | in_valid_i/in_ready_o | data_byte_i, last_byte_i
// out      | out_valid_o/out_ready_i | out_byte_o, out_last_o
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// Bytes pass the queue, then an output register; one byte per cycle in a block unless out_ready_i stalls.
// Each 32-byte block is hashed one SHA-256 round per cycle (load, 64 rounds, capture), started
// when the block comes into use; a byte at a block boundary waits for the digest.
// A new message restarts the engine.
// Reset clears control state and the key and IV registers; a two-entry queue decouples input.
`timescale 1ns / 1ps
`default_nettype none
module hash_chain_keystream_xor_cipher import hcx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [63:0] key_q [4];
  logic [63:0] iv_q;
  head_t       head;
  logic        pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
      iv_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KEY_WORD_0:  key_q[0] <= cfg_data_i;
        REG_KEY_WORD_1:  key_q[1] <= cfg_data_i;
        REG_KEY_WORD_2:  key_q[2] <= cfg_data_i;
        REG_KEY_WORD_3:  key_q[3] <= cfg_data_i;
        REG_INIT_VECTOR: iv_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hcx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .head_o      (head),
    .pop_i       (pop)
  );

  hcx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .key_i       ({key_q[3], key_q[2], key_q[1], key_q[0]}),
    .iv_i        (iv_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule
`default_nettype wire

// ===== design/hcx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcx_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       out_last_o,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("result changed while stalled");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config transfer refused");

  // no result is valid when reset is released
  a_no_early: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

  a_ready_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_o)
    else $error("input not ready after reset");

endmodule

bind hash_chain_keystream_xor_cipher hcx_checker u_hcx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire

// ===== tb/hcx_keystream_checker.sv =====
`timescale 1ns / 1ps
module hcx_keystream_checker import hcx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        out_last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [63:0]  key_q [4];
  logic [63:0]  iv_q;
  logic [63:0]  block_q [4];
  logic [4:0]   pos_q;
  logic         in_msg_q;
  cipher_out_t  expected_bytes [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // block <- SHA-256(block || iv), a single padded 64-byte chunk
  task automatic chain_block();
    logic [7:0]  msg [64];
    logic [31:0] w [64];
    logic [31:0] h [8];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int i = 0; i < 64; i++) msg[i] = 8'h00;
    for (int i = 0; i < 32; i++) msg[i] = block_q[i / 8][8 * (i % 8) +: 8];
    for (int i = 0; i < 8; i++) msg[32 + i] = iv_q[8 * i +: 8];
    msg[40] = 8'h80;
    msg[62] = 8'h01;
    msg[63] = 8'h40;
    for (int i = 0; i < 16; i++) w[i] = {msg[4*i], msg[4*i+1], msg[4*i+2], msg[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    h = InitH;
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + RoundK[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    for (int i = 0; i < 32; i++) block_q[i / 8][8 * (i % 8) +: 8] = h[i / 4][8 * (3 - i % 4) +: 8];
  endtask

  task automatic encrypt_byte(logic [7:0] data, logic last);
    cipher_out_t r;
    if (!in_msg_q) begin
      block_q  = key_q;
      pos_q    = '0;
      in_msg_q = 1'b1;
    end else if (pos_q == 5'd0) begin
      chain_block();
    end
    r.data = data ^ block_q[pos_q[4:3]][8 * pos_q[2:0] +: 8];
    r.last = last;
    expected_bytes.push_back(r);
    pos_q = pos_q + 5'd1;
    if (last) in_msg_q = 1'b0;
  endtask

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: got %02h, want %02h", what, got, want);
    errors_o++;
  endtask

  assign pending_o = expected_bytes.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_out_t want;
    if (!rst_ni) begin
      key_q    = '{default: '0};
      iv_q     = '0;
      block_q  = '{default: '0};
      pos_q    = '0;
      in_msg_q = 1'b0;
      expected_bytes.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_KEY_WORD_0:  key_q[0] = cfg_data_i;
          REG_KEY_WORD_1:  key_q[1] = cfg_data_i;
          REG_KEY_WORD_2:  key_q[2] = cfg_data_i;
          REG_KEY_WORD_3:  key_q[3] = cfg_data_i;
          REG_INIT_VECTOR: iv_q     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) encrypt_byte(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          report("unexpected transfer", out_byte_i, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_i !== want.data) report("out_byte", out_byte_i, want.data);
          if (out_last_i !== want.last) report("out_last", {7'd0, out_last_i}, {7'd0, want.last});
        end
      end
    end
  end

endmodule

// ===== tb/hash_chain_keystream_xor_cipher_tb.sv =====
`timescale 1ns / 1ps
module hash_chain_keystream_xor_cipher_tb import hcx_pkg::*;;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_KEY_WORD_0;
  logic [63:0] cfg_data = '0;
  int          errors;
  int          pending;
  bit          hold_req = 1'b0;
  int          bytes_sent = 0;
  int          messages_sent = 0;
  int          key_settings = 0;
  int          idle_cycles = 0;

  always #4 clk = ~clk;

  hash_chain_keystream_xor_cipher dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .data_byte_i(data_byte), .last_byte_i(last_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_byte_o(out_byte), .out_last_o(out_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  hcx_keystream_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .data_byte_i(data_byte), .last_byte_i(last_byte),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_byte_i(out_byte), .out_last_i(out_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending", idle_cycles, pending);
      $display("hash_chain_keystream_xor_cipher_tb: done, errors");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_byte(logic [7:0] value, logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    data_byte = value;
    last_byte = last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (last) messages_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic load_keys(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                           logic [63:0] k3, logic [63:0] iv);
    cfg_write(REG_KEY_WORD_0, k0);
    cfg_write(REG_KEY_WORD_1, k1);
    cfg_write(REG_KEY_WORD_2, k2);
    cfg_write(REG_KEY_WORD_3, k3);
    cfg_write(REG_INIT_VECTOR, iv);
    key_settings++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_messages(int budget);
    int len, r;
    logic [7:0] v;
    while (budget > 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 40);
      else if (r < 95) len = $urandom_range(41, 100);
      else len = $urandom_range(101, 200);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        v = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom);
        send_byte(v, i == len - 1);
      end
      budget -= len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset key and IV of zero: single-byte messages, then one crossing a block boundary
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < 33; i++) send_byte((i % 2) ? 8'hff : 8'h00, i == 32);
    drain();

    load_keys('1, '1, '1, '1, '1);
    hold_req = 1'b1;
    random_messages(230);
    drain();

    load_keys('0, '0, '0, '0, '1);
    random_messages(230);
    drain();

    load_keys('1, '1, '1, '1, '0);
    random_messages(230);
    drain();

    repeat (3) begin
      load_keys(rand64(), rand64(), rand64(), rand64(), rand64());
      random_messages(230);
      drain();
    end

    $display("covered %0d bytes in %0d messages over %0d key/IV settings",
             bytes_sent, messages_sent, key_settings + 1);
    if (errors == 0) begin
      $display("hash_chain_keystream_xor_cipher_tb: done, clean");
    end else begin
      $display("hash_chain_keystream_xor_cipher_tb: done, errors");
    end
    $finish;
  end

endmodule
